// ===== src/imuspf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU sample pairing FIFO package
// Shared codes, widths and the result record of the sample pairing FIFO.
// ----------------------------------------------------------------------------
package imuspf_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int TIME_W = 64;
  localparam int VAL_W  = 32;

  localparam logic [2:0] SAMPLE_VALUES = 3'd3;
  localparam logic [2:0] STREAM_ACCEL  = 3'b001;
  localparam logic [2:0] STREAM_GYRO   = 3'b010;
  localparam logic [2:0] STREAM_TEMP   = 3'b100;
  localparam logic [2:0] STREAM_ALL    = 3'b111;

  typedef enum logic [1:0] {
    FUNC_ACCEL = 2'd0,
    FUNC_GYRO  = 2'd1,
    FUNC_TEMP  = 2'd2,
    FUNC_READ  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_DATA      = 3'd0,
    KIND_EMPTY     = 3'd1,
    KIND_MISMATCH  = 3'd2,
    KIND_INVALID   = 3'd3,
    KIND_BAD_COUNT = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] gyro_z;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_x;
    logic signed [31:0] accel_z;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_x;
    logic signed [31:0] temperature;
    logic [63:0]        timestamp;
  } result_t;

endpackage
`default_nettype wire

// ===== src/imu_sample_pairing_fifo_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU sample pairing FIFO
// Pairs accelerometer and gyroscope samples into ring entries stamped with
// the latest temperature and returns complete entries on read requests.
// ----------------------------------------------------------------------------
// Results: each result is registered into the output queue when its input transfer is accepted.
// Throughput: one input transfer per cycle while the output queue is not full; the ring
// memories read ahead at the next pointer values, so no item waits on a memory port.
// A two-entry output queue lets input continue while one result is stalled.
// Reset: synchronous; clears the stream flags, pointers, enable register and
// output queue. Unwritten timestamps read as zero.
module imu_sample_pairing_fifo_top
  import imuspf_pkg::*;
#(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // value_count[2:0], sample_time[66:3], value_x[98:67], value_y[130:99],
  // value_z[162:131], zero fill [167:163]
  input  wire logic [167:0] s_tdata,
  // func[1:0], sample_good[2]
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_timestamp[63:0], out_temperature[95:64], out_accel_x[127:96],
  // out_accel_y[159:128], out_accel_z[191:160], out_gyro_x[223:192],
  // out_gyro_y[255:224], out_gyro_z[287:256]
  output logic      [287:0] m_tdata,
  // result_kind[2:0]
  output logic      [2:0]   m_tuser
);

  localparam int AW = $clog2(RING_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  func_t              in_func;
  logic               in_good;
  logic [2:0]         in_count;
  logic [63:0]        in_time;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;

  assign in_func  = func_t'(s_tuser[1:0]);
  assign in_good  = s_tuser[2];
  assign in_count = s_tdata[2:0];
  assign in_time  = s_tdata[66:3];
  assign in_x     = s_tdata[98:67];
  assign in_y     = s_tdata[130:99];
  assign in_z     = s_tdata[162:131];

  logic               enabled;
  logic [2:0]         started, started_next;
  logic [2:0]         stream_valid, stream_valid_next;
  logic               recording, recording_next;
  logic signed [31:0] latest_temp, latest_temp_next;
  logic [AW-1:0]      accel_ptr, accel_ptr_next;
  logic [AW-1:0]      gyro_ptr, gyro_ptr_next;
  logic [AW-1:0]      read_ptr, read_ptr_next;
  logic               wrapped, wrapped_next;

  logic [1:0] out_cnt;
  result_t    slot0;
  result_t    slot1;

  logic       acc;
  logic       pop;
  logic       wr_a;
  logic       wr_g;
  logic       res_valid;
  kind_t      res_kind;
  logic [2:0] bit_sel;
  result_t    res;

  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  gy_addr;
  logic           rd_vld_q;
  logic           gy_vld_q;
  logic [191:0]   a_rd;
  logic [95:0]    g_rd;
  logic [63:0]    t_rd;
  logic [63:0]    gyro_entry_time;

  assign s_tready = !rst && (out_cnt != 2'd2);
  assign acc      = s_tvalid && s_tready;
  assign m_tvalid = (out_cnt != 2'd0);
  assign pop      = m_tvalid && m_tready;

  assign gyro_entry_time = gy_vld_q ? t_rd : '0;

  always_comb begin
    started_next      = started;
    stream_valid_next = stream_valid;
    recording_next    = recording;
    latest_temp_next  = latest_temp;
    accel_ptr_next    = accel_ptr;
    gyro_ptr_next     = gyro_ptr;
    read_ptr_next     = read_ptr;
    wr_a              = 1'b0;
    wr_g              = 1'b0;
    res_valid         = 1'b0;
    res_kind          = KIND_DATA;
    case (in_func)
      FUNC_ACCEL: bit_sel = STREAM_ACCEL;
      FUNC_GYRO:  bit_sel = STREAM_GYRO;
      default:    bit_sel = STREAM_TEMP;
    endcase
    if (acc) begin
      if (in_func == FUNC_READ) begin
        res_valid = 1'b1;
        if (!recording || (read_ptr == gyro_ptr)) begin
          res_kind = KIND_EMPTY;
        end else begin
          res_kind      = KIND_DATA;
          read_ptr_next = ptr_inc(read_ptr);
        end
      end else if (enabled) begin
        started_next = started | bit_sel;
        if (started_next == STREAM_ALL) begin
          if (in_good) begin
            stream_valid_next = stream_valid | bit_sel;
          end
          if (in_good && (in_func == FUNC_TEMP)) begin
            latest_temp_next = in_x;
          end else begin
            if ((in_func == FUNC_ACCEL) && (stream_valid_next == STREAM_ALL)) begin
              recording_next = 1'b1;
            end
            if (recording_next) begin
              if (!in_good) begin
                res_valid = 1'b1;
                res_kind  = KIND_INVALID;
              end else if (in_count != SAMPLE_VALUES) begin
                res_valid = 1'b1;
                res_kind  = KIND_BAD_COUNT;
              end else if (in_func == FUNC_ACCEL) begin
                wr_a           = 1'b1;
                accel_ptr_next = ptr_inc(accel_ptr);
                if (accel_ptr_next == read_ptr) begin
                  read_ptr_next = ptr_inc(read_ptr);
                end
              end else if (gyro_entry_time != in_time) begin
                res_valid = 1'b1;
                res_kind  = KIND_MISMATCH;
              end else begin
                wr_g          = 1'b1;
                gyro_ptr_next = ptr_inc(gyro_ptr);
              end
            end
          end
        end
      end
    end
  end

  assign wrapped_next = wrapped || (wr_a && (accel_ptr == LAST));

  assign rd_addr = rst ? '0 : read_ptr_next;
  assign gy_addr = rst ? '0 : gyro_ptr_next;

  // Entries are written in pointer order, so an entry holds a timestamp once
  // the accel pointer has passed it or has wrapped at least once.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld_q <= 1'b0;
      gy_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= wrapped_next || (rd_addr < accel_ptr_next);
      gy_vld_q <= wrapped_next || (gy_addr < accel_ptr_next);
    end
  end

  imuspf_ram #(
    .WIDTH (192),
    .DEPTH (RING_DEPTH)
  ) u_accel_ram (
    .clk (clk),
    .we  (wr_a),
    .wa  (accel_ptr),
    .wd  ({in_z, in_y, in_x, latest_temp, in_time}),
    .ra  (rd_addr),
    .rd  (a_rd)
  );

  imuspf_ram #(
    .WIDTH (64),
    .DEPTH (RING_DEPTH)
  ) u_time_ram (
    .clk (clk),
    .we  (wr_a),
    .wa  (accel_ptr),
    .wd  (in_time),
    .ra  (gy_addr),
    .rd  (t_rd)
  );

  imuspf_ram #(
    .WIDTH (96),
    .DEPTH (RING_DEPTH)
  ) u_gyro_ram (
    .clk (clk),
    .we  (wr_g),
    .wa  (gyro_ptr),
    .wd  ({in_z, in_y, in_x}),
    .ra  (rd_addr),
    .rd  (g_rd)
  );

  always_comb begin
    res      = '0;
    res.kind = res_kind;
    if (res_kind == KIND_DATA) begin
      res.timestamp   = rd_vld_q ? a_rd[63:0] : '0;
      res.temperature = a_rd[95:64];
      res.accel_x     = a_rd[127:96];
      res.accel_y     = a_rd[159:128];
      res.accel_z     = a_rd[191:160];
      res.gyro_x      = g_rd[31:0];
      res.gyro_y      = g_rd[63:32];
      res.gyro_z      = g_rd[95:64];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled      <= 1'b0;
      started      <= '0;
      stream_valid <= '0;
      recording    <= 1'b0;
      latest_temp  <= '0;
      accel_ptr    <= '0;
      gyro_ptr     <= '0;
      read_ptr     <= '0;
      wrapped      <= 1'b0;
    end else begin
      if (cfg_we) begin
        enabled <= cfg_wdata;
      end
      started      <= started_next;
      stream_valid <= stream_valid_next;
      recording    <= recording_next;
      latest_temp  <= latest_temp_next;
      accel_ptr    <= accel_ptr_next;
      gyro_ptr     <= gyro_ptr_next;
      read_ptr     <= read_ptr_next;
      wrapped      <= wrapped_next;
    end
  end

  logic push;
  assign push = acc && res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else begin
      if (pop) begin
        if (out_cnt == 2'd2) begin
          slot0 <= slot1;
          if (push) begin
            slot1 <= res;
          end
        end else if (push) begin
          slot0 <= res;
        end
      end else if (push) begin
        if (out_cnt == 2'd0) begin
          slot0 <= res;
        end else begin
          slot1 <= res;
        end
      end
      out_cnt <= out_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  assign m_tuser = slot0.kind;
  assign m_tdata = {slot0.gyro_z, slot0.gyro_y, slot0.gyro_x, slot0.accel_z,
                    slot0.accel_y, slot0.accel_x, slot0.temperature, slot0.timestamp};

endmodule
`default_nettype wire

// ===== src/imuspf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IMU sample pairing FIFO ring memory
// One write port and one registered read port; a write to the address being
// read in the same cycle is returned on the read side.
// ----------------------------------------------------------------------------
module imuspf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output logic      [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_q;
  logic [WIDTH-1:0] wd_q;
  logic             hit_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q  <= mem[ra];
    wd_q  <= wd;
    hit_q <= we && (wa == ra);
  end

  assign rd = hit_q ? wd_q : rd_q;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU sample pairing FIFO testbench
// Drives accelerometer, gyroscope, temperature and read transfers into the
// pairing FIFO with random gaps and output stalls. It predicts each result
// from its own model of the stream gating and the ring, and checks every
// returned result field by field.
// ----------------------------------------------------------------------------
module tb;
  import imuspf_pkg::*;

  typedef struct {
    func_t              func;
    logic               good;
    logic [2:0]         count;
    logic [63:0]        ts;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } sample_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic         cfg_wdata = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [167:0] s_tdata = '0;
  logic [2:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [287:0] m_tdata;
  logic [2:0]   m_tuser;

  imu_sample_pairing_fifo_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Model state of the pairing FIFO.
  logic               enabled_now = 1'b0;
  logic [2:0]         started_mask = '0;
  logic [2:0]         good_mask = '0;
  logic               rec_on = 1'b0;
  logic signed [31:0] temp_now = '0;
  int                 ac_ptr = 0;
  int                 gy_ptr = 0;
  int                 rd_ptr = 0;
  logic [63:0]        time_mem [RING_DEPTH_DEF];
  logic signed [31:0] temp_mem [RING_DEPTH_DEF];
  logic signed [31:0] accel_mem [RING_DEPTH_DEF][3];
  logic signed [31:0] gyro_mem [RING_DEPTH_DEF][3];

  sample_t     imu_items[$];
  result_t     awaited_replies[$];
  logic [63:0] unpaired_stamps[$];
  logic        gen_enabled = 1'b0;
  logic        gen_recording = 1'b0;
  logic        send_idle_on = 1'b1;
  logic        recv_idle_on = 1'b1;
  logic        in_fire = 1'b0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          error_count = 0;
  int          items_sent = 0;
  int          results_checked = 0;
  int          ring_overflows = 0;
  int          kind_seen[5] = '{0, 0, 0, 0, 0};

  function automatic int ring_next(int p);
    return (p + 1) % RING_DEPTH_DEF;
  endfunction

  function automatic bit predict_pairing(input sample_t s, output result_t res);
    logic [2:0] stream_bit;
    res = '0;
    if (s.func == FUNC_READ) begin
      if (!rec_on || rd_ptr == gy_ptr) begin
        res.kind = KIND_EMPTY;
        return 1;
      end
      res.kind = KIND_DATA;
      res.timestamp = time_mem[rd_ptr];
      res.temperature = temp_mem[rd_ptr];
      res.accel_x = accel_mem[rd_ptr][0];
      res.accel_y = accel_mem[rd_ptr][1];
      res.accel_z = accel_mem[rd_ptr][2];
      res.gyro_x = gyro_mem[rd_ptr][0];
      res.gyro_y = gyro_mem[rd_ptr][1];
      res.gyro_z = gyro_mem[rd_ptr][2];
      rd_ptr = ring_next(rd_ptr);
      return 1;
    end
    if (!enabled_now) return 0;
    case (s.func)
      FUNC_ACCEL: stream_bit = STREAM_ACCEL;
      FUNC_GYRO: stream_bit = STREAM_GYRO;
      default: stream_bit = STREAM_TEMP;
    endcase
    started_mask = started_mask | stream_bit;
    if (started_mask != STREAM_ALL) return 0;
    if (s.good) begin
      good_mask = good_mask | stream_bit;
      if (s.func == FUNC_TEMP) begin
        temp_now = s.vx;
        return 0;
      end
    end
    if (s.func == FUNC_ACCEL && good_mask == STREAM_ALL) rec_on = 1'b1;
    if (!rec_on) return 0;
    if (!s.good) begin
      res.kind = KIND_INVALID;
      return 1;
    end
    if (s.count != SAMPLE_VALUES) begin
      res.kind = KIND_BAD_COUNT;
      return 1;
    end
    if (s.func == FUNC_ACCEL) begin
      time_mem[ac_ptr] = s.ts;
      temp_mem[ac_ptr] = temp_now;
      accel_mem[ac_ptr][0] = s.vx;
      accel_mem[ac_ptr][1] = s.vy;
      accel_mem[ac_ptr][2] = s.vz;
      ac_ptr = ring_next(ac_ptr);
      if (ac_ptr == rd_ptr) begin
        rd_ptr = ring_next(rd_ptr);
        ring_overflows++;
      end
      return 0;
    end
    if (time_mem[gy_ptr] != s.ts) begin
      res.kind = KIND_MISMATCH;
      return 1;
    end
    gyro_mem[gy_ptr][0] = s.vx;
    gyro_mem[gy_ptr][1] = s.vy;
    gyro_mem[gy_ptr][2] = s.vz;
    gy_ptr = ring_next(gy_ptr);
    return 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h",
                                                name, got, want));
  endtask

  always @(posedge clk) begin
    sample_t s;
    result_t want;
    result_t got;
    in_fire <= s_tvalid && s_tready;
    if (rst) begin
      enabled_now = 1'b0;
      started_mask = '0;
      good_mask = '0;
      rec_on = 1'b0;
      temp_now = '0;
      ac_ptr = 0;
      gy_ptr = 0;
      rd_ptr = 0;
      for (int i = 0; i < RING_DEPTH_DEF; i++) time_mem[i] = '0;
    end else begin
      if (cfg_we) enabled_now = cfg_wdata;
      if (s_tvalid && s_tready) begin
        s.func = func_t'(s_tuser[1:0]);
        s.good = s_tuser[2];
        s.count = s_tdata[2:0];
        s.ts = s_tdata[66:3];
        s.vx = s_tdata[98:67];
        s.vy = s_tdata[130:99];
        s.vz = s_tdata[162:131];
        items_sent++;
        if (predict_pairing(s, want)) awaited_replies.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        results_checked++;
        if (awaited_replies.size() == 0) begin
          report_mismatch($sformatf("unexpected result of kind %0d", m_tuser));
        end else begin
          want = awaited_replies.pop_front();
          kind_seen[want.kind]++;
          check_field("result_kind", got.kind, want.kind);
          check_field("out_timestamp", got.timestamp, want.timestamp);
          check_field("out_temperature", got.temperature, want.temperature);
          check_field("out_accel_x", got.accel_x, want.accel_x);
          check_field("out_accel_y", got.accel_y, want.accel_y);
          check_field("out_accel_z", got.accel_z, want.accel_z);
          check_field("out_gyro_x", got.gyro_x, want.gyro_x);
          check_field("out_gyro_y", got.gyro_y, want.gyro_y);
          check_field("out_gyro_z", got.gyro_z, want.gyro_z);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    sample_t it;
    if (!s_tvalid || in_fire) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (imu_items.size() > 0) begin
        it = imu_items.pop_front();
        s_tdata <= {5'd0, it.vz, it.vy, it.vx, it.ts, it.count};
        s_tuser <= {it.good, it.func};
        s_tvalid <= 1'b1;
        send_gap <= send_idle_on ? pick_gap() : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
    if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (recv_idle_on && $urandom_range(0, 3) == 0) recv_stall <= pick_gap();
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [2:0] wrong_count();
    logic [2:0] c;
    c = 3'($urandom_range(0, 6));
    if (c >= SAMPLE_VALUES) c = c + 3'd1;
    return c;
  endfunction

  function automatic sample_t make_sample(func_t f, logic good, logic [2:0] count,
                                          logic [63:0] ts);
    sample_t s;
    s.func = f;
    s.good = good;
    s.count = count;
    s.ts = ts;
    s.vx = $urandom;
    s.vy = $urandom;
    s.vz = $urandom;
    return s;
  endfunction

  // Tracks the timestamps of opened entries still waiting for gyro data, so a
  // gyroscope sample never pairs with a ring entry that was never opened.
  function automatic void queue_item(sample_t s);
    if (s.func == FUNC_GYRO && s.ts == '0 && unpaired_stamps.size() == 0) s.ts = 64'd1;
    if (gen_enabled && gen_recording && s.good && s.count == SAMPLE_VALUES) begin
      if (s.func == FUNC_ACCEL) begin
        unpaired_stamps.push_back(s.ts);
      end else if (s.func == FUNC_GYRO && unpaired_stamps.size() > 0) begin
        if (s.ts == unpaired_stamps[0]) void'(unpaired_stamps.pop_front());
      end
    end
    imu_items.push_back(s);
  endfunction

  function automatic void add_random_sequence(int read_pct);
    int          r;
    logic [63:0] t;
    r = $urandom_range(0, 99);
    if (unpaired_stamps.size() > 6) begin
      queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, unpaired_stamps[0]));
    end else if (r < read_pct) begin
      queue_item(make_sample(FUNC_READ, 1'($urandom), 3'($urandom), rand64()));
    end else if (r < read_pct + 12) begin
      queue_item(make_sample(func_t'($urandom_range(0, 2)), 1'($urandom), 3'($urandom),
                             rand64()));
    end else if (r < read_pct + 18) begin
      queue_item(make_sample(FUNC_TEMP, $urandom_range(0, 4) != 0, 3'($urandom), rand64()));
    end else begin
      t = ($urandom_range(0, 19) == 0) ? 64'($urandom_range(0, 3)) : rand64();
      queue_item(make_sample(FUNC_ACCEL, 1'b1, SAMPLE_VALUES, t));
      if ($urandom_range(0, 3) == 0) begin
        queue_item(make_sample(FUNC_TEMP, 1'b1, 3'($urandom), rand64()));
      end
      r = $urandom_range(0, 19);
      if (r == 0) begin
        queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES,
                               unpaired_stamps[0] ^ (rand64() | 64'd1)));
      end else if (r == 1) begin
        queue_item(make_sample(FUNC_GYRO, 1'b0, 3'($urandom), unpaired_stamps[0]));
      end else if (r == 2) begin
        queue_item(make_sample(FUNC_GYRO, 1'b1, wrong_count(), unpaired_stamps[0]));
      end else if (r != 3) begin
        queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, unpaired_stamps[0]));
      end
    end
  endfunction

  task automatic wait_idle();
    while (imu_items.size() != 0 || s_tvalid) @(posedge clk);
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_enable(input logic value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    gen_enabled = value;
  endtask

  initial begin
    sample_t s;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    queue_item(make_sample(FUNC_READ, 1'b1, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_ACCEL, 1'b1, SAMPLE_VALUES, rand64()));
    wait_idle();
    write_enable(1'b1);

    queue_item(make_sample(FUNC_ACCEL, 1'b1, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_TEMP, 1'b0, 3'd0, rand64()));
    queue_item(make_sample(FUNC_ACCEL, 1'b0, SAMPLE_VALUES, rand64()));
    s = make_sample(FUNC_TEMP, 1'b1, 3'd7, 64'd0);
    s.vx = 32'sh7fffffff;
    queue_item(s);
    queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_READ, 1'b0, 3'd0, 64'd0));
    gen_recording = 1'b1;
    s = make_sample(FUNC_ACCEL, 1'b1, SAMPLE_VALUES, 64'd0);
    s.vx = 32'sh80000000;
    s.vy = 32'sh7fffffff;
    s.vz = -32'sd1;
    queue_item(s);
    queue_item(make_sample(FUNC_READ, 1'b1, 3'd7, '1));
    s = make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, 64'd0);
    s.vx = 32'sh7fffffff;
    s.vy = 32'sh80000000;
    s.vz = 32'sd0;
    queue_item(s);
    queue_item(make_sample(FUNC_READ, 1'b0, 3'd0, 64'd0));
    queue_item(make_sample(FUNC_READ, 1'b1, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_ACCEL, 1'b1, 3'd7, rand64()));
    queue_item(make_sample(FUNC_GYRO, 1'b1, 3'd0, rand64()));
    queue_item(make_sample(FUNC_ACCEL, 1'b0, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_TEMP, 1'b0, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_GYRO, 1'b0, SAMPLE_VALUES, rand64()));
    queue_item(make_sample(FUNC_ACCEL, 1'b1, SAMPLE_VALUES, '1));
    queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, 64'd5));
    s = make_sample(FUNC_TEMP, 1'b1, SAMPLE_VALUES, rand64());
    s.vx = 32'sh80000000;
    queue_item(s);
    queue_item(make_sample(FUNC_GYRO, 1'b1, SAMPLE_VALUES, '1));
    queue_item(make_sample(FUNC_READ, 1'b1, SAMPLE_VALUES, rand64()));
    wait_idle();

    repeat (175) add_random_sequence(5);
    wait_idle();

    write_enable(1'b0);
    send_idle_on = 1'b0;
    repeat (40) begin
      if ($urandom_range(0, 9) < 7) begin
        queue_item(make_sample(FUNC_READ, 1'($urandom), 3'($urandom), rand64()));
      end else begin
        queue_item(make_sample(func_t'($urandom_range(0, 2)), 1'($urandom), 3'($urandom),
                               rand64()));
      end
    end
    wait_idle();

    write_enable(1'b1);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b0;
    repeat (150) add_random_sequence(45);
    wait_idle();

    send_idle_on = 1'b0;
    repeat (130) add_random_sequence(20);
    wait_idle();

    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    repeat (140) add_random_sequence(25);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Sent %0d transfers and checked %0d results: %0d data, %0d empty,",
             items_sent, results_checked, kind_seen[KIND_DATA], kind_seen[KIND_EMPTY]);
    $display("%0d time mismatch, %0d invalid, %0d bad count; %0d ring overflows.",
             kind_seen[KIND_MISMATCH], kind_seen[KIND_INVALID], kind_seen[KIND_BAD_COUNT],
             ring_overflows);
    if (error_count == 0 && awaited_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(64'd20 * 64'd1000000);
    $display("Timeout waiting for the pairing FIFO.");
    $display("Test completed with failures");
    $finish;
  end

endmodule
